>>> hdl/mvn_pkg.sv
// Package for the mesh vertex normal unit: shared types, request codes, widths.
// No dependencies.
`default_nettype none
package mvn_pkg;
  localparam int MaxVertices = 1024;
  localparam int MaxFaces    = 2048;
  localparam int MaxAdj      = 63;

  localparam int VIdxW = 10;
  localparam int FIdxW = 11;
  localparam int PosW  = 16;
  localparam int FnW   = 35;
  localparam int SumW  = 41;
  localparam int NrmW  = 16;

  localparam logic [1:0] REQ_VLOAD = 2'd0;
  localparam logic [1:0] REQ_FLOAD = 2'd1;
  localparam logic [1:0] REQ_ADJ   = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOADJ = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [VIdxW-1:0] vertex_index;
    logic [FIdxW-1:0] face_index;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [PosW-1:0]  pos_z;
    logic [VIdxW-1:0] corner_a;
    logic [VIdxW-1:0] corner_b;
    logic [VIdxW-1:0] corner_c;
  } req_t;
endpackage
`default_nettype wire

>>> hdl/mvn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mvn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/mvn_front.sv
// Front end: accepts requests, drops out-of-range ones, queues them for the back end.
// Depends on mvn_pkg.
`default_nettype none
module mvn_front #(
  parameter int MaxVertices = mvn_pkg::MaxVertices,
  parameter int MaxFaces    = mvn_pkg::MaxFaces
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  mvn_pkg::req_t      req,
  output logic               busy,
  output logic               q_valid,
  output mvn_pkg::req_t      q_req,
  input  wire logic          q_pop
);
  import mvn_pkg::*;
  localparam int QDepth = 2;
  req_t       qmem [QDepth];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop, keep;

  always_comb begin
    keep = 1'b1;
    case (req.req_type)
      REQ_VLOAD: keep = 32'(req.vertex_index) < MaxVertices;
      REQ_FLOAD: keep = 32'(req.face_index) < MaxFaces;
      REQ_ADJ:   keep = 32'(req.vertex_index) < MaxVertices
                     && 32'(req.face_index) < MaxFaces;
      REQ_READ:  keep = 1'b1;
      default:   keep = 1'b1;
    endcase
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy && keep;
  assign pop     = q_pop && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_req   = qmem[rptr];

  always_ff @(posedge clk) begin
    if (push) qmem[wptr] <= req;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("bad count");
`endif
endmodule
`default_nettype wire

>>> hdl/mvn_back.sv
// Back end: sequencer over position, face-normal and sum memories, with an
// iterative square root and divider for normal reads. Depends on mvn_pkg, mvn_ram.
`default_nettype none
module mvn_back #(
  parameter int MaxVertices = mvn_pkg::MaxVertices,
  parameter int MaxFaces    = mvn_pkg::MaxFaces,
  parameter int MaxAdj      = mvn_pkg::MaxAdj
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  mvn_pkg::req_t        q_req,
  output logic                 q_pop,
  output logic                 done,
  output logic signed [15:0]   normal_x,
  output logic signed [15:0]   normal_y,
  output logic signed [15:0]   normal_z,
  output logic [1:0]           status
);
  import mvn_pkg::*;
  localparam int VAW  = $clog2(MaxVertices);
  localparam int FAW  = $clog2(MaxFaces);
  localparam int CntW = $clog2(MaxAdj + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_ADJ = 4'd2, S_C1 = 4'd3,
                         S_C2 = 4'd4, S_C3 = 4'd5, S_CR = 4'd6, S_CR2 = 4'd7,
                         S_NRM = 4'd8, S_SQ = 4'd9, S_SQRT = 4'd10,
                         S_DIV = 4'd11, S_OUT = 4'd12, S_VZ = 4'd13,
                         S_CLR = 4'd14;
  logic [3:0] state;

  req_t r;
  // position RAM
  logic            p_we;
  logic [VAW-1:0]  p_wa, p_ra;
  logic [47:0]     p_wd, p_rd;
  mvn_ram #(.Width(48), .Depth(MaxVertices)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  // face normal RAM
  logic            f_we;
  logic [FAW-1:0]  f_a;
  logic [3*FnW-1:0] f_wd, f_rd;
  mvn_ram #(.Width(3*FnW), .Depth(MaxFaces)) u_fn (
    .clk(clk), .we(f_we), .waddr(f_a), .wdata(f_wd), .raddr(f_a), .rdata(f_rd));
  // sum + count RAM
  logic            s_we;
  logic [VAW-1:0]  s_a;
  logic [3*SumW+CntW-1:0] s_wd, s_rd;
  mvn_ram #(.Width(3*SumW+CntW), .Depth(MaxVertices)) u_sum (
    .clk(clk), .we(s_we), .waddr(s_a), .wdata(s_wd), .raddr(s_a), .rdata(s_rd));
  // after reset a clearing pass zeroes every sum and count, one entry a cycle
  logic [VAW-1:0] clr_addr;

  logic signed [16:0] px0, py0, pz0, e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [33:0] pa, pb;
  logic [1:0]  ci;
  logic [1:0]  crk;
  logic signed [FnW-1:0] nx, ny;
  logic [40:0] a0, a1, a2;
  logic [2:0]  sg;
  logic [63:0] q, res, bitv;
  logic [30:0] lr;
  logic [1:0]  dk;
  logic [46:0] rem;
  logic [15:0] quo;
  logic [4:0]  dbit;
  logic signed [15:0] ox, oy, oz;
  logic [1:0]  ost;

  wire signed [SumW-1:0] sx = s_rd[3*SumW+CntW-1 -: SumW];
  wire signed [SumW-1:0] sy = s_rd[2*SumW+CntW-1 -: SumW];
  wire signed [SumW-1:0] sz = s_rd[SumW+CntW-1 -: SumW];
  wire [CntW-1:0]        sc = s_rd[CntW-1:0];
  wire signed [16:0] rx = 17'(signed'(p_rd[47:32]));
  wire signed [16:0] ry = 17'(signed'(p_rd[31:16]));
  wire signed [16:0] rz = 17'(signed'(p_rd[15:0]));
  logic cvalid;
  logic [40:0] mm;
  logic [5:0]  tnext;
  logic [29:0] sq_op;
  logic [59:0] sq_term;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign mm = a0 | a1 | a2;
  always_comb begin
    tnext = 6'd0;
    for (int i = 0; i < 41; i++) if (mm[i]) tnext = 6'(i);
  end
  // one 30x30 square per cycle
  always_comb begin
    case (dk)
      2'd0: sq_op = a0[29:0];
      2'd1: sq_op = a1[29:0];
      default: sq_op = a2[29:0];
    endcase
    sq_term = sq_op * sq_op;
  end
  always_comb begin
    p_we = 1'b0; p_wa = r.vertex_index[VAW-1:0];
    p_wd = {r.pos_x, r.pos_y, r.pos_z};
    p_ra = r.corner_a[VAW-1:0];
    case (ci)
      2'd1: p_ra = r.corner_b[VAW-1:0];
      2'd2: p_ra = r.corner_c[VAW-1:0];
      default: p_ra = r.corner_a[VAW-1:0];
    endcase
    if (state == S_IDLE) p_ra = q_req.corner_a[VAW-1:0];
    f_we = 1'b0; f_a = (state == S_IDLE) ? q_req.face_index[FAW-1:0]
                                         : r.face_index[FAW-1:0];
    f_wd = {nx, ny, FnW'(pa) - FnW'(pb)};
    s_we = 1'b0; s_a = (state == S_IDLE) ? q_req.vertex_index[VAW-1:0]
                                         : r.vertex_index[VAW-1:0];
    s_wd = '0;
    if (state == S_CLR) begin
      s_we = 1'b1; s_a = clr_addr;
    end
    if (state == S_VZ) begin
      p_we = 1'b1; s_we = 1'b1;
    end
    if (state == S_ADJ && 32'(sc) < MaxAdj) begin
      s_we = 1'b1;
      s_wd = {sx + SumW'(signed'(f_rd[3*FnW-1 -: FnW])),
              sy + SumW'(signed'(f_rd[2*FnW-1 -: FnW])),
              sz + SumW'(signed'(f_rd[FnW-1:0])), sc + CntW'(1)};
    end
    if (state == S_CR2 && crk == 2'd2) f_we = 1'b1;
  end

  wire [31:0] q_idx = 32'(q_req.corner_a);
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; done <= 1'b0; clr_addr <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          if (clr_addr == VAW'(MaxVertices - 1)) state <= S_IDLE;
          clr_addr <= clr_addr + VAW'(1);
        end
        S_IDLE: if (q_valid) begin
          r <= q_req; ci <= 2'd0;
          cvalid <= q_idx < MaxVertices;
          case (q_req.req_type)
            REQ_VLOAD: state <= S_VZ;
            REQ_FLOAD: state <= S_C1;
            REQ_ADJ:   state <= S_RD;
            default:   state <= S_RD;
          endcase
        end
        S_VZ: state <= S_IDLE;
        S_RD: begin
          if (r.req_type == REQ_ADJ) state <= S_ADJ;
          else begin
            a0 <= sx[SumW-1] ? 41'(-sx) : 41'(sx);
            a1 <= sy[SumW-1] ? 41'(-sy) : 41'(sy);
            a2 <= sz[SumW-1] ? 41'(-sz) : 41'(sz);
            sg <= {sx[SumW-1], sy[SumW-1], sz[SumW-1]};
            ox <= '0; oy <= '0; oz <= '0;
            if (32'(r.vertex_index) >= MaxVertices || sc == '0) begin
              ost <= ST_NOADJ; state <= S_OUT;
            end else if (sx == '0 && sy == '0 && sz == '0) begin
              ost <= ST_ZERO; state <= S_OUT;
            end else begin
              ost <= ST_OK; state <= S_NRM;
            end
          end
        end
        S_ADJ: state <= S_IDLE;
        S_C1: begin
          // registered read of corner a lands now
          ci <= 2'd1; state <= S_C2;
        end
        S_C2: begin
          px0 <= cvalid ? rx : '0; py0 <= cvalid ? ry : '0; pz0 <= cvalid ? rz : '0;
          cvalid <= 32'(r.corner_b) < MaxVertices;
          ci <= 2'd2; state <= S_C3;
        end
        S_C3: begin
          e1x <= px0 - (cvalid ? rx : 17'sd0);
          e1y <= py0 - (cvalid ? ry : 17'sd0);
          e1z <= pz0 - (cvalid ? rz : 17'sd0);
          cvalid <= 32'(r.corner_c) < MaxVertices;
          state <= S_CR;
        end
        S_CR: begin
          e2x <= px0 - (cvalid ? rx : 17'sd0);
          e2y <= py0 - (cvalid ? ry : 17'sd0);
          e2z <= pz0 - (cvalid ? rz : 17'sd0);
          crk <= 2'd0; state <= S_CR2;
        end
        S_CR2: begin
          case (crk)
            2'd0: begin pa <= e1y * e2z; pb <= e1z * e2y; end
            2'd1: begin nx <= FnW'(pa) - FnW'(pb);
                        pa <= e1z * e2x; pb <= e1x * e2z; end
            2'd2: begin state <= S_IDLE; end
            default: ;
          endcase
          if (crk == 2'd1) begin
            // third pair issued next cycle
          end
          if (crk == 2'd0) crk <= 2'd1;
          else if (crk == 2'd1) crk <= 2'd3;
          else if (crk == 2'd3) begin
            ny <= FnW'(pa) - FnW'(pb);
            pa <= e1x * e2y; pb <= e1y * e2x; crk <= 2'd2;
          end
        end
        S_NRM: begin
          if (tnext > 6'd29) begin
            a0 <= a0 >> (tnext - 6'd29); a1 <= a1 >> (tnext - 6'd29);
            a2 <= a2 >> (tnext - 6'd29);
          end else begin
            a0 <= a0 << (6'd29 - tnext); a1 <= a1 << (6'd29 - tnext);
            a2 <= a2 << (6'd29 - tnext);
          end
          q <= '0; dk <= 2'd0; state <= S_SQ;
        end
        S_SQ: begin
          q <= q + 64'(sq_term);
          if (dk == 2'd2) begin
            res <= '0; bitv <= 64'd1 << 62; state <= S_SQRT;
          end
          dk <= dk + 2'd1;
        end
        S_SQRT: begin
          if (bitv > q && res == '0 && bitv != '0) bitv <= bitv >> 2;
          else if (bitv != '0) begin
            if (q >= res + bitv) begin
              q <= q - (res + bitv); res <= (res >> 1) + bitv;
            end else res <= res >> 1;
            bitv <= bitv >> 2;
          end else begin
            lr <= res[30:0]; dk <= 2'd0;
            rem <= {2'b0, a0[29:0], 15'd0} + 47'(res[30:0]);
            quo <= '0; dbit <= 5'd16; state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dbit != 5'd0) begin
            if (rem >= (47'({lr, 1'b0}) << (dbit - 5'd1))) begin
              rem <= rem - (47'({lr, 1'b0}) << (dbit - 5'd1));
              quo <= quo | (16'd1 << (dbit - 5'd1));
            end
            dbit <= dbit - 5'd1;
          end else begin
            case (dk)
              2'd0: begin ox <= sg[2] ? -quo : quo;
                rem <= {2'b0, a1[29:0], 15'd0} + 47'(lr); end
              2'd1: begin oy <= sg[1] ? -quo : quo;
                rem <= {2'b0, a2[29:0], 15'd0} + 47'(lr); end
              default: oz <= sg[0] ? -quo : quo;
            endcase
            quo <= '0; dbit <= 5'd16;
            if (dk == 2'd2) state <= S_OUT;
            dk <= dk + 2'd1;
          end
        end
        S_OUT: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end
  assign normal_x = ox;
  assign normal_y = oy;
  assign normal_z = oz;
  assign status = ost;

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("strobe outside idle");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("nonzero normal on error");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE) else $error("pop without work");
`endif
endmodule
`default_nettype wire

>>> hdl/mesh_vertex_normal_unit.sv
// Top level of the mesh vertex normal unit: front queue plus back-end sequencer.
// Depends on mvn_pkg, mvn_front, mvn_back, mvn_ram.
//
// Usage: present a request with start high; it is taken at an edge where busy
// is low. req_type selects vertex load, face load, adjacency entry or normal
// read. Out-of-range vertex loads, face loads and adjacency entries are dropped
// in the front end. Accepted requests pass through a two-entry transaction
// queue to the back end, which runs one transaction at a time; busy is high
// while the queue holds two.
// Back-end work per transaction: a face load makes three position reads
// through the one read port, then three multiplier passes; a normal read
// runs a normalize shift, three squares on one multiplier, a bit-pair square
// root and three restoring divisions, unless it answers an error status.
// A normal read answers with a one-cycle strobe on done; the receiver cannot
// stall, so results are never held. Reset empties the queue and starts a
// clearing pass that zeroes every sum and count; the queue still takes up to
// two transactions meanwhile.
`default_nettype none
module mesh_vertex_normal_unit #(
  parameter int MaxVertices = mvn_pkg::MaxVertices,
  parameter int MaxFaces    = mvn_pkg::MaxFaces,
  parameter int MaxAdj      = mvn_pkg::MaxAdj
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [9:0]  vertex_index,
  input  wire logic [10:0] face_index,
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic [15:0] pos_z,
  input  wire logic [9:0]  corner_a,
  input  wire logic [9:0]  corner_b,
  input  wire logic [9:0]  corner_c,
  output logic             done,
  output logic [15:0]      normal_x,
  output logic [15:0]      normal_y,
  output logic [15:0]      normal_z,
  output logic [1:0]       status
);
  import mvn_pkg::*;
  req_t req, q_req;
  logic q_valid, q_pop;

  assign req = '{req_type, vertex_index, face_index, pos_x, pos_y, pos_z,
                 corner_a, corner_b, corner_c};

  mvn_front #(.MaxVertices(MaxVertices), .MaxFaces(MaxFaces)) u_front (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop));

  mvn_back #(.MaxVertices(MaxVertices), .MaxFaces(MaxFaces), .MaxAdj(MaxAdj)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .status(status));
endmodule
`default_nettype wire
